[hw/rtl/sbs_pkg.sv]
// ---------------------------------------------------------------------------
// sbs_pkg
// Shared constants, types and the control program of the sorted table
// binary search block.
// ---------------------------------------------------------------------------
package sbs_pkg;

   // Field widths of the item and result channels.
   localparam int MODE_W  = 3;
   localparam int LEN_W   = 11;
   localparam int VALUE_W = 32;

   // Default table size.
   localparam int TABLE_DEPTH_DEF = 1024;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_EXACT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_CEIL  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FLOOR = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FIRST = 3'd4;
   localparam logic [MODE_W-1:0] MODE_LAST  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_COUNT = 3'd6;

   // Program steps of the sequencer.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TEST = 3'd1;
   localparam logic [STEP_W-1:0] STEP_CMP  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DONE = 3'd3;
   localparam logic [STEP_W-1:0] STEP_EMIT = 3'd4;

   // Jump conditions.
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER       = 3'd0;
   localparam logic [COND_W-1:0] COND_QUERY       = 3'd1;
   localparam logic [COND_W-1:0] COND_RANGE_EMPTY = 3'd2;
   localparam logic [COND_W-1:0] COND_EXACT_HIT   = 3'd3;
   localparam logic [COND_W-1:0] COND_PASS_AGAIN  = 3'd4;
   localparam logic [COND_W-1:0] COND_OUT_BLOCKED = 3'd5;

   // One control word of the program.
   typedef struct packed {
      logic                take_item;  // input channel open
      logic                issue_read; // latch probe and read the table
      logic                compare;    // narrow the range from the probe
      logic                restart;    // start the second count pass
      logic                emit;       // load the result register
      logic [COND_W-1:0]   cond;
      logic [STEP_W-1:0]   jump;
      logic [STEP_W-1:0]   next;
   } uword_type;

   // Control store: the search program.
   function automatic uword_type ucode(input logic [STEP_W-1:0] step);
      uword_type w;
      w = '0;
      unique case (step)
         STEP_IDLE: begin
            w.take_item = 1'b1;
            w.cond      = COND_QUERY;
            w.jump      = STEP_TEST;
            w.next      = STEP_IDLE;
         end
         STEP_TEST: begin
            w.issue_read = 1'b1;
            w.cond       = COND_RANGE_EMPTY;
            w.jump       = STEP_DONE;
            w.next       = STEP_CMP;
         end
         STEP_CMP: begin
            w.compare = 1'b1;
            w.cond    = COND_EXACT_HIT;
            w.jump    = STEP_DONE;
            w.next    = STEP_TEST;
         end
         STEP_DONE: begin
            w.restart = 1'b1;
            w.cond    = COND_PASS_AGAIN;
            w.jump    = STEP_TEST;
            w.next    = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.emit = 1'b1;
            w.cond = COND_OUT_BLOCKED;
            w.jump = STEP_EMIT;
            w.next = STEP_IDLE;
         end
         default: begin
            w.cond = COND_NEVER;
            w.jump = STEP_IDLE;
            w.next = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

[hw/rtl/sbs_ram.sv]
// ---------------------------------------------------------------------------
// sbs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
module sbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/sorted_table_binary_search_top.sv]
// ---------------------------------------------------------------------------
// sorted_table_binary_search_top
// Ascending table of signed values with binary search queries, driven by a
// small microcoded sequencer.
// ---------------------------------------------------------------------------
// Usage:
// Load items (mode 0) write one table entry at a 1-based position; they
// produce no result. Positions 0 and above TABLE_DEPTH are dropped. Query
// items (exact, ceiling, floor, first, last) return one result item with
// found, position and occurrences; count items run a first-occurrence pass
// then a last-occurrence pass. Mode 7 is dropped.
// csr_wr_en writes table_length, the number of entries searched; write it
// and load the table only while no query is in flight.
// Each probe is a table read step followed by a compare step; count items
// repeat the probe loop for their second pass. The single read port of the
// table RAM and the shared compare step keep the probes sequential. One
// query is in flight at a time, and the next item can be taken in the cycle
// after the result is loaded.
// Reset clears table_length and all control state and stalls the item
// channel; the table content is undefined until loaded. A stalled result
// holds in the output register; the next item is taken meanwhile, and a
// query finishing behind it waits.
// ---------------------------------------------------------------------------
module sorted_table_binary_search_top #(
   parameter int TABLE_DEPTH = sbs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Configuration port.
   input  logic                        csr_wr_en,
   input  logic [sbs_pkg::LEN_W-1:0]   csr_wr_data,
   // Item channel.
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sbs_pkg::MODE_W-1:0]  req_mode,
   input  logic [sbs_pkg::LEN_W-1:0]   req_entry_index,
   input  logic signed [sbs_pkg::VALUE_W-1:0] req_entry_value,
   input  logic signed [sbs_pkg::VALUE_W-1:0] req_search_key,
   // Result channel.
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [sbs_pkg::LEN_W-1:0]   rsp_position,
   output logic [sbs_pkg::LEN_W-1:0]   rsp_occurrences
);

   import sbs_pkg::*;

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int DEPTH_W = $clog2(TABLE_DEPTH + 2);
   localparam int POS_W   = (DEPTH_W > LEN_W) ? DEPTH_W : LEN_W;

   // Registers.
   logic [LEN_W-1:0]          len_ff;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [MODE_W-1:0]         kind_ff, kind_in;
   logic                      count_ff, count_in;
   logic signed [VALUE_W-1:0] key_ff, key_in;
   logic [POS_W-1:0]          lo_ff, lo_in;
   logic [POS_W-1:0]          hi_ff, hi_in;
   logic [POS_W-1:0]          mid_ff, mid_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [POS_W-1:0]          first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      found_ff, found_in;
   logic [LEN_W-1:0]          position_ff, position_in;
   logic [LEN_W-1:0]          occ_ff, occ_in;

   // Datapath signals.
   uword_type                 uw;
   logic                      cond_true;
   logic                      req_take;
   logic                      is_query;
   logic [POS_W-1:0]          hi_start;
   logic [POS_W:0]            mid_sum;
   logic [POS_W-1:0]          mid_calc;
   logic                      range_empty;
   logic signed [VALUE_W-1:0] entry;
   logic                      key_eq;
   logic                      key_lt;
   logic                      out_blocked;
   logic [POS_W-1:0]          idx_ext;
   logic                      load_we;
   logic [ADDR_W-1:0]         load_addr;
   logic [POS_W-1:0]          occ_full;

   // Table length register.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_wr_en) begin
         len_ff <= csr_wr_data;
      end
   end

   // Fetch the control word of the current step.
   assign uw = ucode(step_ff);

   // The item channel stays closed during reset.
   assign req_stall = reset | ~uw.take_item;
   assign req_take  = req_valid & ~req_stall;
   assign is_query  = (req_mode != MODE_LOAD) & (req_mode <= MODE_COUNT);

   // Search range bounds and probe position.
   assign hi_start    = (POS_W'(len_ff) > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                                : POS_W'(len_ff);
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc    = mid_sum[POS_W:1];
   assign range_empty = lo_ff > hi_ff;

   // Probe compare against the table word read in the previous step.
   assign key_eq = key_ff == entry;
   assign key_lt = key_ff < entry;

   assign out_blocked = rsp_valid_ff & rsp_stall;

   // Load item decode.
   assign idx_ext   = POS_W'(req_entry_index);
   assign load_we   = req_take & (req_mode == MODE_LOAD) & (idx_ext != '0)
                      & (idx_ext <= POS_W'(TABLE_DEPTH));
   assign load_addr = ADDR_W'(idx_ext - POS_W'(1));

   // Table storage.
   sbs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (load_addr),
      .wr_data (req_entry_value),
      .rd_en   (uw.issue_read),
      .rd_addr (ADDR_W'(mid_calc - POS_W'(1))),
      .rd_data (entry)
   );

   // Jump condition select.
   always_comb begin
      unique case (uw.cond)
         COND_NEVER:       cond_true = 1'b0;
         COND_QUERY:       cond_true = req_take & is_query;
         COND_RANGE_EMPTY: cond_true = range_empty;
         COND_EXACT_HIT:   cond_true = (kind_ff == MODE_EXACT) & key_eq;
         COND_PASS_AGAIN:  cond_true = count_ff & (kind_ff == MODE_FIRST);
         COND_OUT_BLOCKED: cond_true = out_blocked;
         default:          cond_true = 1'b0;
      endcase
   end

   assign step_in = cond_true ? uw.jump : uw.next;

   // Datapath actions of the current control word.
   always_comb begin
      kind_in  = kind_ff;
      count_in = count_ff;
      key_in   = key_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      pos_in   = pos_ff;
      first_in = first_ff;

      // Start a query from the accepted item.
      if (uw.take_item && req_take && is_query) begin
         count_in = req_mode == MODE_COUNT;
         kind_in  = (req_mode == MODE_COUNT) ? MODE_FIRST : req_mode;
         key_in   = req_search_key;
         lo_in    = POS_W'(1);
         hi_in    = hi_start;
         pos_in   = '0;
      end

      if (uw.issue_read) begin
         mid_in = mid_calc;
      end

      // Narrow the range according to the search kind.
      if (uw.compare) begin
         unique case (kind_ff)
            MODE_EXACT: begin
               if (key_eq) begin
                  pos_in = mid_ff;
               end else if (key_lt) begin
                  hi_in = mid_ff - POS_W'(1);
               end else begin
                  lo_in = mid_ff + POS_W'(1);
               end
            end
            MODE_CEIL: begin
               if (key_lt || key_eq) begin
                  pos_in = mid_ff;
                  hi_in  = mid_ff - POS_W'(1);
               end else begin
                  lo_in = mid_ff + POS_W'(1);
               end
            end
            MODE_FLOOR: begin
               if (!key_lt) begin
                  pos_in = mid_ff;
                  lo_in  = mid_ff + POS_W'(1);
               end else begin
                  hi_in = mid_ff - POS_W'(1);
               end
            end
            MODE_FIRST: begin
               if (key_eq) begin
                  pos_in = mid_ff;
                  hi_in  = mid_ff - POS_W'(1);
               end else if (key_lt) begin
                  hi_in = mid_ff - POS_W'(1);
               end else begin
                  lo_in = mid_ff + POS_W'(1);
               end
            end
            default: begin
               if (key_eq) begin
                  pos_in = mid_ff;
                  lo_in  = mid_ff + POS_W'(1);
               end else if (key_lt) begin
                  hi_in = mid_ff - POS_W'(1);
               end else begin
                  lo_in = mid_ff + POS_W'(1);
               end
            end
         endcase
      end

      // Keep the first occurrence and run the last-occurrence pass.
      if (uw.restart && cond_true) begin
         first_in = pos_ff;
         kind_in  = MODE_LAST;
         lo_in    = POS_W'(1);
         hi_in    = hi_start;
         pos_in   = '0;
      end
   end

   // Result formatting.
   assign occ_full = pos_ff - first_ff + POS_W'(1);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      found_in     = found_ff;
      position_in  = position_ff;
      occ_in       = occ_ff;
      if (uw.emit && !out_blocked) begin
         rsp_valid_in = 1'b1;
         if (count_ff) begin
            found_in    = (first_ff != '0) & (pos_ff != '0) & (pos_ff >= first_ff);
            position_in = '0;
            occ_in      = ((first_ff != '0) && (pos_ff != '0) && (pos_ff >= first_ff))
                          ? LEN_W'(occ_full) : '0;
         end else begin
            found_in    = pos_ff != '0;
            position_in = LEN_W'(pos_ff);
            occ_in      = '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      count_ff    <= count_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      pos_ff      <= pos_in;
      first_ff    <= first_in;
      found_ff    <= found_in;
      position_ff <= position_in;
      occ_ff      <= occ_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_position    = position_ff;
   assign rsp_occurrences = occ_ff;

   // A miss never carries a position or a count.
   a_miss_is_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_position == '0 && rsp_occurrences == '0))
      else $error("miss result carries a position or count");

   // A count result never carries a position.
   a_count_no_position: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_occurrences != '0) |-> (rsp_found && rsp_position == '0))
      else $error("count result carries a position");

   // Every probe lies inside the searched part of the table.
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff == STEP_CMP) |-> (mid_ff != '0 && mid_ff <= hi_start))
      else $error("probe outside the table");

   // A new result is loaded only on the way back to the idle step.
   a_emit_to_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (step_ff == STEP_IDLE))
      else $error("result loaded outside the emit step");

endmodule

[sim/sorted_table_binary_search_top_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_table_binary_search_top_test
// Self-checking bench for the sorted table search block. A short scripted
// sequence covers the empty table, ignored items, value extremes and every
// query mode. Random phases then follow. Each phase sets a table length,
// may load a fresh ascending (now and then unordered) table, and sends random
// queries. Every result is checked against a bench-side model of the table.
// ---------------------------------------------------------------------------
module sorted_table_binary_search_top_test;
   import sbs_pkg::*;

   localparam int TABLE_DEPTH   = sbs_pkg::TABLE_DEPTH_DEF;
   localparam int ITEM_TARGET   = 1650;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 60;
   localparam int MAX_REPORTS   = 10;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   // One result item of a query.
   typedef struct packed {
      logic             found;
      logic [LEN_W-1:0] position;
      logic [LEN_W-1:0] occurrences;
   } lookup_type;

   // One row of the scripted sequence: a length write or an item.
   typedef struct {
      bit                        set_len;
      logic [MODE_W-1:0]         mode;
      logic [LEN_W-1:0]          index;
      logic signed [VALUE_W-1:0] value;
      logic signed [VALUE_W-1:0] key;
      bit                        typed;
      lookup_type                result;
   } script_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [LEN_W-1:0]          csr_wr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode = MODE_LOAD;
   logic [LEN_W-1:0]          req_entry_index = '0;
   logic signed [VALUE_W-1:0] req_entry_value = '0;
   logic signed [VALUE_W-1:0] req_search_key = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_found;
   logic [LEN_W-1:0]          rsp_position;
   logic [LEN_W-1:0]          rsp_occurrences;

   // Bench copy of the table and the length register.
   logic signed [VALUE_W-1:0] table_mem [1:TABLE_DEPTH];
   logic [LEN_W-1:0]          cfg_len = '0;
   lookup_type                pending_lookups [$];
   script_row_type            script [$];

   int unsigned items_done = 0;
   int unsigned loads_done = 0;
   int unsigned lookups_done = 0;
   int unsigned results_checked = 0;
   int unsigned errors = 0;
   int unsigned phases = 0;
   int unsigned longest_len = 0;
   int unsigned quiet_cycles = 0;
   int unsigned no_gap_left = 0;
   int unsigned calm_left = 0;
   int unsigned hold_left = 0;
   int unsigned stall_roll;
   lookup_type  want;

   sorted_table_binary_search_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_occurrences (rsp_occurrences)
   );

   always #6 clock = ~clock;

   // Binary search over positions 1..length; returns the chosen position or 0.
   function automatic int probe_search(logic [MODE_W-1:0] kind,
                                       logic signed [VALUE_W-1:0] key);
      int lo;
      int hi;
      int mid;
      int pos;
      logic signed [VALUE_W-1:0] e;
      lo  = 1;
      hi  = (cfg_len > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_len);
      pos = 0;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         e   = table_mem[mid];
         case (kind)
            MODE_EXACT: begin
               if (key == e) return mid;
               if (key < e) hi = mid - 1;
               else lo = mid + 1;
            end
            MODE_CEIL: begin
               if (key <= e) begin
                  pos = mid;
                  hi  = mid - 1;
               end else lo = mid + 1;
            end
            MODE_FLOOR: begin
               if (key >= e) begin
                  pos = mid;
                  lo  = mid + 1;
               end else hi = mid - 1;
            end
            MODE_FIRST: begin
               if (key == e) begin
                  pos = mid;
                  hi  = mid - 1;
               end else if (key > e) lo = mid + 1;
               else hi = mid - 1;
            end
            default: begin
               if (key == e) begin
                  pos = mid;
                  lo  = mid + 1;
               end else if (key > e) lo = mid + 1;
               else hi = mid - 1;
            end
         endcase
      end
      return pos;
   endfunction

   // Applies an accepted item to the bench table and queues the result it causes.
   function automatic void absorb_item(logic [MODE_W-1:0] m, logic [LEN_W-1:0] idx,
                                       logic signed [VALUE_W-1:0] val,
                                       logic signed [VALUE_W-1:0] key,
                                       bit typed, lookup_type typed_res);
      lookup_type r;
      int first_pos;
      int last_pos;
      int p;
      r = '0;
      if (m == MODE_LOAD) begin
         if (idx >= 1 && idx <= TABLE_DEPTH) begin
            table_mem[idx] = val;
            loads_done++;
            items_done++;
         end
         return;
      end
      if (m == MODE_UNUSED) return;
      items_done++;
      lookups_done++;
      if (m == MODE_COUNT) begin
         first_pos = probe_search(MODE_FIRST, key);
         last_pos  = probe_search(MODE_LAST, key);
         if (first_pos > 0 && last_pos > 0 && last_pos >= first_pos) begin
            r.found       = 1'b1;
            r.occurrences = LEN_W'(last_pos - first_pos + 1);
         end
      end else begin
         p = probe_search(m, key);
         if (p > 0) begin
            r.found    = 1'b1;
            r.position = LEN_W'(p);
         end
      end
      pending_lookups.push_back(typed ? typed_res : r);
   endfunction

   // Idle span: mostly short, a few long.
   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Gap before the next item, with occasional runs of back-to-back items.
   function automatic int unsigned sender_gap();
      if (no_gap_left > 0) begin
         no_gap_left--;
         return 0;
      end
      if ($urandom_range(0, 99) < 2) begin
         no_gap_left = $urandom_range(20, 60);
         return 0;
      end
      if ($urandom_range(0, 99) < 60) return 0;
      return idle_span();
   endfunction

   // Key choice: mostly table values and their neighbors, some extremes and noise.
   function automatic logic signed [VALUE_W-1:0] pick_key(int unsigned span);
      int unsigned roll;
      logic signed [VALUE_W-1:0] k;
      roll = $urandom_range(0, 99);
      if (span > 0 && roll < 60) k = table_mem[$urandom_range(1, span)];
      else if (span > 0 && roll < 80)
         k = table_mem[$urandom_range(1, span)] + ($urandom_range(0, 1) ? 1 : -1);
      else if (roll < 90) begin
         case ($urandom_range(0, 3))
            0: k = KEY_MIN;
            1: k = KEY_MAX;
            2: k = '0;
            default: k = -1;
         endcase
      end else k = $urandom;
      return k;
   endfunction

   function automatic void plan_item(logic [MODE_W-1:0] m, logic [LEN_W-1:0] idx,
                                     logic signed [VALUE_W-1:0] val,
                                     logic signed [VALUE_W-1:0] key, bit typed = 0,
                                     bit f = 0, int p = 0, int o = 0);
      script_row_type row;
      row.set_len = 1'b0;
      row.mode    = m;
      row.index   = idx;
      row.value   = val;
      row.key     = key;
      row.typed   = typed;
      row.result  = {f, LEN_W'(p), LEN_W'(o)};
      script.push_back(row);
   endfunction

   function automatic void plan_length(logic [LEN_W-1:0] len);
      script_row_type row;
      row         = '{default: '0};
      row.set_len = 1'b1;
      row.value   = len;
      script.push_back(row);
   endfunction

   // Presents one item at the falling edge and holds it until it is taken.
   task automatic send_item(logic [MODE_W-1:0] m, logic [LEN_W-1:0] idx,
                            logic signed [VALUE_W-1:0] val,
                            logic signed [VALUE_W-1:0] key,
                            bit typed, lookup_type typed_res);
      int unsigned gap;
      gap = sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= m;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_search_key  <= key;
      do @(posedge clock); while (req_stall);
      absorb_item(m, idx, val, key, typed, typed_res);
   endtask

   // Items the block drops: unused mode or a load outside the table.
   task automatic send_noise();
      if ($urandom_range(0, 1))
         send_item(MODE_UNUSED, LEN_W'($urandom), $urandom, $urandom, 0, '0);
      else
         send_item(MODE_LOAD,
                   LEN_W'($urandom_range(0, 1) ? 0 : $urandom_range(TABLE_DEPTH + 1, 2047)),
                   $urandom, $urandom, 0, '0);
   endtask

   // Stops sending and waits until the block has nothing left in flight.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(logic [LEN_W-1:0] len);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      csr_wr_data <= LEN_W'($urandom);
      cfg_len = len;
   endtask

   // Loads positions 1..count in shuffled order, ascending unless asked otherwise.
   task automatic load_table(int unsigned count, bit unsorted);
      int unsigned order [];
      logic signed [VALUE_W-1:0] vals [];
      longint level;
      int unsigned cap;
      int unsigned swap;
      int unsigned tmp;
      order = new[count];
      vals  = new[count];
      case ($urandom_range(0, 2))
         0: level = -64'sd2147483648;
         1: level = longint'($signed($urandom));
         default: level = longint'($urandom_range(0, 40)) - 20;
      endcase
      case ($urandom_range(0, 2))
         0: cap = 2;
         1: cap = 5000;
         default: cap = int'(64'd4294967296 / (count + 1));
      endcase
      for (int j = 0; j < count; j++) begin
         if (unsorted) vals[j] = $urandom_range(0, 15) - 8;
         else begin
            vals[j] = level[VALUE_W-1:0];
            if ($urandom_range(0, 2) != 0) level += longint'($urandom_range(0, cap));
            if (level > 2147483647) level = 2147483647;
         end
         order[j] = j + 1;
      end
      for (int j = count - 1; j > 0; j--) begin
         swap        = $urandom_range(0, j);
         tmp         = order[j];
         order[j]    = order[swap];
         order[swap] = tmp;
      end
      for (int j = 0; j < count; j++) begin
         if ($urandom_range(0, 24) == 0) send_noise();
         send_item(MODE_LOAD, LEN_W'(order[j]), vals[order[j] - 1], $urandom, 0, '0);
      end
   endtask

   // Random queries, with a few dropped items and stray loads mixed in.
   task automatic run_queries(int unsigned count, int unsigned span);
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) send_noise();
         else if (roll < 7)
            send_item(MODE_LOAD, LEN_W'($urandom_range(1, TABLE_DEPTH)), pick_key(span),
                      $urandom, 0, '0);
         else
            send_item(MODE_W'($urandom_range(MODE_EXACT, MODE_COUNT)), LEN_W'($urandom),
                      $urandom, pick_key(span), 0, '0);
      end
   endtask

   // One phase: new length, optional fresh table, then queries.
   task automatic run_phase(int unsigned len, bit reload, bit unsorted, int unsigned queries);
      int unsigned span;
      span = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      phases++;
      if (len > longest_len) longest_len = len;
      settle_block();
      write_length(LEN_W'(len));
      if (reload && span > 0) load_table(span, unsorted);
      run_queries(queries, span);
   endtask

   // Result side stall pattern, changed at the falling edge.
   always @(negedge clock) begin
      if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 3) begin
            calm_left = $urandom_range(20, 100);
            rsp_stall <= 1'b0;
         end else if (stall_roll < 25) begin
            hold_left = idle_span() - 1;
            rsp_stall <= 1'b1;
         end else rsp_stall <= 1'b0;
      end
   end

   // Result checker: each taken result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_lookups.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("Unexpected result: found %0b position %0d occurrences %0d",
                        rsp_found, rsp_position, rsp_occurrences);
         end else begin
            want = pending_lookups.pop_front();
            results_checked++;
            if (rsp_found !== want.found || rsp_position !== want.position ||
                rsp_occurrences !== want.occurrences) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("Result %0d: found %0b/%0b pos %0d/%0d occ %0d/%0d (exp/act)",
                           results_checked, want.found, rsp_found, want.position,
                           rsp_position, want.occurrences, rsp_occurrences);
            end
         end
      end
   end

   // Watchdog on cycles without any handshake or register write.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_lookups.size());
         $display("** sorted_table_binary_search_top: FAILED **");
         $finish;
      end
   end

   initial begin
      for (int i = 1; i <= TABLE_DEPTH; i++) table_mem[i] = '0;

      // Scripted part: empty table after reset, dropped items, then a small
      // table with both value extremes and a run of three duplicates.
      plan_item(MODE_EXACT, 0, 0, 0, 1, 0, 0, 0);
      plan_item(MODE_COUNT, 0, 0, -1, 1, 0, 0, 0);
      plan_item(MODE_LOAD, 0, 123, 0);
      plan_item(MODE_LOAD, TABLE_DEPTH + 1, 456, 0);
      plan_item(MODE_LOAD, 2047, -789, 0);
      plan_item(MODE_UNUSED, 2047, KEY_MIN, KEY_MAX);
      plan_item(MODE_LOAD, TABLE_DEPTH, KEY_MAX, 0);
      plan_item(MODE_LOAD, 1, KEY_MIN, 0);
      plan_item(MODE_LOAD, 2, 5, 0);
      plan_item(MODE_LOAD, 3, 5, 0);
      plan_item(MODE_LOAD, 4, 5, 0);
      plan_item(MODE_LOAD, 5, KEY_MAX, 0);
      plan_length(5);
      plan_item(MODE_EXACT, 0, 0, KEY_MIN, 1, 1, 1, 0);
      plan_item(MODE_EXACT, 0, 0, 5);
      plan_item(MODE_CEIL, 0, 0, 6, 1, 1, 5, 0);
      plan_item(MODE_CEIL, 0, 0, KEY_MIN, 1, 1, 1, 0);
      plan_item(MODE_FLOOR, 0, 0, KEY_MIN, 1, 1, 1, 0);
      plan_item(MODE_FLOOR, 0, 0, 4, 1, 1, 1, 0);
      plan_item(MODE_FLOOR, 0, 0, KEY_MAX, 1, 1, 5, 0);
      plan_item(MODE_FIRST, 0, 0, 5, 1, 1, 2, 0);
      plan_item(MODE_LAST, 0, 0, 5, 1, 1, 4, 0);
      plan_item(MODE_COUNT, 0, 0, 5, 1, 1, 0, 3);
      plan_item(MODE_COUNT, 0, 0, 6, 1, 0, 0, 0);
      plan_item(MODE_EXACT, 0, 0, 6, 1, 0, 0, 0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].set_len) begin
            settle_block();
            write_length(script[i].value[LEN_W-1:0]);
         end else
            send_item(script[i].mode, script[i].index, script[i].value, script[i].key,
                      script[i].typed, script[i].result);
      end

      // Random phases: small table, full table, oversize length, empty, then mixed.
      run_phase($urandom_range(2, 12), 1, 0, 20);
      run_phase(TABLE_DEPTH, 1, 0, 60);
      run_phase(2047, 0, 0, 30);
      run_phase(0, 0, 0, 8);
      while (items_done < ITEM_TARGET) begin
         case ($urandom_range(0, 15))
            0: run_phase(0, 0, 0, 8);
            1: run_phase(1, 1, 0, 10);
            2: run_phase($urandom_range(TABLE_DEPTH + 1, 2047), 0, 0, 25);
            3: run_phase($urandom_range(48, TABLE_DEPTH), 0, 0, 25);
            default: run_phase($urandom_range(2, 40), 1, $urandom_range(0, 5) == 0,
                               $urandom_range(10, 30));
         endcase
      end

      // Drain the last results, then give the block time to show stray output.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_lookups.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d loads and %0d queries over %0d phases, table lengths 0 to %0d.",
               loads_done, lookups_done, phases, longest_len);
      $display("Checked %0d results, %0d errors.", results_checked, errors);
      if (errors == 0 && pending_lookups.size() == 0)
         $display("** sorted_table_binary_search_top: PASSED **");
      else
         $display("** sorted_table_binary_search_top: FAILED **");
      $finish;
   end

endmodule
